### hw/rtl/ema_env_pkg.sv
// Shared types and constants of the EMA filter with envelope tracker.
// Used by ema_env_ctrl, ema_env_dp and ema_filter_with_envelope_tracker.
package ema_env_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int ETA_W           = 10;
    localparam int PERIOD_W        = 16;
    localparam int INIT_W          = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    localparam logic [ETA_W-1:0] PERMILLE  = 10'd1000;
    localparam logic [INIT_W-1:0] MIN_FLOOR = 8'd1;
    localparam logic [INIT_W-1:0] MAX_GAP   = 8'd5;

    localparam logic [ETA_W-1:0]    RST_ETA_MAIN   = 10'd100;
    localparam logic [ETA_W-1:0]    RST_ETA_SLOW   = 10'd10;
    localparam logic [ETA_W-1:0]    RST_ETA_QUICK  = 10'd500;
    localparam logic [PERIOD_W-1:0] RST_PERIOD     = 16'd100;
    localparam logic [INIT_W-1:0]   RST_INIT_MIN   = 8'd0;
    localparam logic [INIT_W-1:0]   RST_INIT_MAX   = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_ETA_MAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ETA_SLOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ETA_QUICK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_MAX   = 3'd5;

    typedef enum logic [1:0] {
        SEL_FILT,
        SEL_LOW,
        SEL_HIGH
    } blend_sel_t;

    typedef struct packed {
        logic       accept;
        logic       mul;
        logic       add;
        logic       rcp;
        logic       fix;
        logic       load_out;
        blend_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic due;
    } dp_status_t;

endpackage

### hw/rtl/ema_env_ctrl.sv
// Controller of the EMA filter with envelope tracker: sequences the shared
// blend unit and owns the output valid flag. Depends on ema_env_pkg.
module ema_env_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  ema_env_pkg::dp_status_t status,
    output ema_env_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_RCP,
        ST_FIX,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    ema_env_pkg::blend_sel_t sel_reg;
    ema_env_pkg::blend_sel_t sel_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.accept     = 1'b0;
        cmd.mul        = 1'b0;
        cmd.add        = 1'b0;
        cmd.rcp        = 1'b0;
        cmd.fix        = 1'b0;
        cmd.load_out   = 1'b0;
        cmd.sel        = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.due)
                    begin
                        sel_next   = ema_env_pkg::SEL_FILT;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_RCP;
            end
            ST_RCP:
            begin
                cmd.rcp    = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix = 1'b1;
                case (sel_reg)
                    ema_env_pkg::SEL_FILT:
                    begin
                        sel_next   = ema_env_pkg::SEL_LOW;
                        state_next = ST_MUL;
                    end
                    ema_env_pkg::SEL_LOW:
                    begin
                        sel_next   = ema_env_pkg::SEL_HIGH;
                        state_next = ST_MUL;
                    end
                    default:
                    begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= ema_env_pkg::SEL_FILT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/ema_env_dp.sv
// Datapath of the EMA filter with envelope tracker: configuration registers,
// tick counter, filter and envelope state, shared blend unit, output register.
// Depends on ema_env_pkg.
module ema_env_dp #(
    parameter int SAMPLE_BITS = ema_env_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ema_env_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ema_env_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [SAMPLE_BITS-1:0]               sample,
    input  ema_env_pkg::dp_cmd_t                 cmd,
    output ema_env_pkg::dp_status_t              status,
    output logic [SAMPLE_BITS-1:0]               filtered,
    output logic [SAMPLE_BITS-1:0]               env_low,
    output logic [SAMPLE_BITS-1:0]               env_high
);

    localparam int ENV_W   = (SAMPLE_BITS > 9) ? SAMPLE_BITS : 9;
    localparam int AW      = ENV_W + 10;
    localparam int RCP_W   = AW - 9;
    localparam int RCP_M   = (1 << AW) / 1000;
    localparam int PROD_W  = AW + RCP_W;
    localparam int ETA_W   = ema_env_pkg::ETA_W;
    localparam int PER_W   = ema_env_pkg::PERIOD_W;
    localparam int INIT_W  = ema_env_pkg::INIT_W;

    localparam logic [RCP_W-1:0] RCP_MV = RCP_W'(RCP_M);
    localparam logic [PER_W-1:0] TICK_MAX = {PER_W{1'b1}};

    logic [ETA_W-1:0]       eta_main_reg;
    logic [ETA_W-1:0]       eta_slow_reg;
    logic [ETA_W-1:0]       eta_quick_reg;
    logic [PER_W-1:0]       period_reg;
    logic [INIT_W-1:0]      init_min_reg;
    logic [INIT_W-1:0]      init_max_reg;

    logic                   seeded_reg;
    logic [PER_W-1:0]       tick_reg;
    logic [SAMPLE_BITS-1:0] filt_reg;
    logic [ENV_W-1:0]       low_reg;
    logic [ENV_W-1:0]       high_reg;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [AW-1:0]          p1_reg;
    logic [AW-1:0]          p2_reg;
    logic [AW-1:0]          acc_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [SAMPLE_BITS-1:0] out_filt_reg;
    logic [SAMPLE_BITS-1:0] out_low_reg;
    logic [SAMPLE_BITS-1:0] out_high_reg;

    logic [PER_W-1:0]       tick_inc;
    logic [ENV_W-1:0]       filt_ext;
    logic [ENV_W-1:0]       fresh_sel;
    logic [ENV_W-1:0]       old_sel;
    logic [ETA_W-1:0]       eta_sel;
    logic [ETA_W-1:0]       w_new;
    logic [ETA_W-1:0]       w_old;
    logic [AW-1:0]          p1_next;
    logic [AW-1:0]          p2_next;
    logic [ENV_W-1:0]       q_est;
    logic [AW-1:0]          q_ext;
    logic [AW-1:0]          q_times;
    logic [AW-1:0]          rem;
    logic [ENV_W-1:0]       q_fix;
    logic [SAMPLE_BITS-1:0] q_val;
    logic [SAMPLE_BITS-1:0] q_floor;
    logic [INIT_W-1:0]      seed_lo;
    logic [INIT_W-1:0]      seed_hi;
    logic [ENV_W-1:0]       seed_high;

    assign tick_inc   = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 1'b1;
    assign status.due = seeded_reg && (tick_inc >= period_reg);

    assign filt_ext = ENV_W'(filt_reg);

    always_comb
    begin
        case (cmd.sel)
            ema_env_pkg::SEL_LOW:
            begin
                fresh_sel = filt_ext;
                old_sel   = low_reg;
                eta_sel   = (filt_ext >= low_reg) ? eta_slow_reg : eta_quick_reg;
            end
            ema_env_pkg::SEL_HIGH:
            begin
                fresh_sel = filt_ext;
                old_sel   = high_reg;
                eta_sel   = (filt_ext <= high_reg) ? eta_slow_reg : eta_quick_reg;
            end
            default:
            begin
                fresh_sel = ENV_W'(sample_reg);
                old_sel   = filt_ext;
                eta_sel   = eta_main_reg;
            end
        endcase
    end

    assign w_new   = (eta_sel > ema_env_pkg::PERMILLE) ? ema_env_pkg::PERMILLE : eta_sel;
    assign w_old   = ema_env_pkg::PERMILLE - w_new;
    assign p1_next = AW'(w_new) * AW'(fresh_sel);
    assign p2_next = AW'(w_old) * AW'(old_sel);

    // floor(acc / 1000): reciprocal estimate, then one correction step
    assign q_est   = prod_reg[AW +: ENV_W];
    assign q_ext   = AW'(q_est);
    assign q_times = (q_ext << 10) - (q_ext << 4) - (q_ext << 3);
    assign rem     = acc_reg - q_times;
    assign q_fix   = (rem >= AW'(ema_env_pkg::PERMILLE)) ? q_est + 1'b1 : q_est;
    assign q_val   = q_fix[SAMPLE_BITS-1:0];
    assign q_floor = (q_val == '0) ? SAMPLE_BITS'(1) : q_val;

    assign seed_lo   = (init_min_reg < ema_env_pkg::MIN_FLOOR) ?
                       ema_env_pkg::MIN_FLOOR : init_min_reg;
    assign seed_hi   = (init_max_reg < ema_env_pkg::MIN_FLOOR) ?
                       ema_env_pkg::MIN_FLOOR : init_max_reg;
    assign seed_high = (seed_hi < seed_lo) ?
                       ENV_W'(seed_lo) + ENV_W'(ema_env_pkg::MAX_GAP) : ENV_W'(seed_hi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_main_reg  <= ema_env_pkg::RST_ETA_MAIN;
            eta_slow_reg  <= ema_env_pkg::RST_ETA_SLOW;
            eta_quick_reg <= ema_env_pkg::RST_ETA_QUICK;
            period_reg    <= ema_env_pkg::RST_PERIOD;
            init_min_reg  <= ema_env_pkg::RST_INIT_MIN;
            init_max_reg  <= ema_env_pkg::RST_INIT_MAX;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ema_env_pkg::CFG_ETA_MAIN:      eta_main_reg  <= cfg_data[ETA_W-1:0];
                ema_env_pkg::CFG_ETA_SLOW:      eta_slow_reg  <= cfg_data[ETA_W-1:0];
                ema_env_pkg::CFG_ETA_QUICK:     eta_quick_reg <= cfg_data[ETA_W-1:0];
                ema_env_pkg::CFG_SAMPLE_PERIOD: period_reg    <= cfg_data[PER_W-1:0];
                ema_env_pkg::CFG_INITIAL_MIN:   init_min_reg  <= cfg_data[INIT_W-1:0];
                ema_env_pkg::CFG_INITIAL_MAX:   init_max_reg  <= cfg_data[INIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg <= 1'b0;
            tick_reg   <= '0;
            filt_reg   <= '0;
            low_reg    <= ENV_W'(1);
            high_reg   <= ENV_W'(1);
        end
        else if (cmd.accept)
        begin
            if (!seeded_reg)
            begin
                seeded_reg <= 1'b1;
                tick_reg   <= '0;
                filt_reg   <= sample;
                low_reg    <= ENV_W'(seed_lo);
                high_reg   <= seed_high;
            end
            else
            begin
                tick_reg <= status.due ? '0 : tick_inc;
            end
        end
        else if (cmd.fix)
        begin
            case (cmd.sel)
                ema_env_pkg::SEL_LOW:  low_reg  <= ENV_W'(q_floor);
                ema_env_pkg::SEL_HIGH: high_reg <= ENV_W'(q_floor);
                default:               filt_reg <= q_val;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample;
        end
        if (cmd.mul)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
        if (cmd.add)
        begin
            acc_reg <= p1_reg + p2_reg;
        end
        if (cmd.rcp)
        begin
            prod_reg <= PROD_W'(acc_reg) * PROD_W'(RCP_MV);
        end
        if (cmd.load_out)
        begin
            out_filt_reg <= filt_reg;
            out_low_reg  <= low_reg[SAMPLE_BITS-1:0];
            out_high_reg <= high_reg[SAMPLE_BITS-1:0];
        end
    end

    assign filtered = out_filt_reg;
    assign env_low  = out_low_reg;
    assign env_high = out_high_reg;

endmodule

### hw/rtl/ema_filter_with_envelope_tracker.sv
// Top level of the EMA filter with min/max envelope tracker.
// Depends on ema_env_pkg, ema_env_ctrl and ema_env_dp.
//
// Usage:
//   s_axis carries one tick per transaction, with the ADC sample in tdata.
//   The first tick after reset seeds the filter and loads both envelopes from
//   the initial_min and initial_max registers; it yields no result. Later
//   ticks advance a counter, and every sample_period-th tick takes a reading.
//   A reading yields one m_axis transaction: filtered value, low envelope
//   and high envelope.
//   A tick without a reading leaves the block ready for the next tick. A
//   reading runs from acceptance to m_axis_tvalid as three blends, each through
//   the one shared multiply / reciprocal-divide unit, plus the output load.
//   The cfg channel writes register cfg_index with cfg_data; it is always
//   ready; the user must write it only while the block is idle (not enforced).
//   Reset restores the register defaults and returns to the unseeded state.
//   A stalled m_axis holds its result in the output register; ticks are still
//   accepted meanwhile, and a reading finishing behind it waits for the
//   output register to free up, with no tick accepted until then.
module ema_filter_with_envelope_tracker #(
    parameter int SAMPLE_BITS = ema_env_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ema_env_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ema_env_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // filtered, env_low, env_high
    output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata
);

    localparam int OUT_TDATA_W = ((3*SAMPLE_BITS+7)/8)*8;

    ema_env_pkg::dp_cmd_t    cmd;
    ema_env_pkg::dp_status_t status;
    logic [SAMPLE_BITS-1:0]  filtered;
    logic [SAMPLE_BITS-1:0]  env_low;
    logic [SAMPLE_BITS-1:0]  env_high;

    assign cfg_ready = 1'b1;

    ema_env_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    ema_env_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .cmd       (cmd),
        .status    (status),
        .filtered  (filtered),
        .env_low   (env_low),
        .env_high  (env_high)
    );

    assign m_axis_tdata = OUT_TDATA_W'({env_high, env_low, filtered});

    a_env_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (env_low != '0) && (env_high != '0))
        else $error("envelope output is zero");

    a_busy_after_reading: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && status.due) |=> !s_axis_tready)
        else $error("tick accepted while a reading is in progress");

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten before transfer");

    a_one_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.accept, cmd.mul, cmd.add, cmd.rcp, cmd.fix, cmd.load_out}) <= 1)
        else $error("datapath received conflicting commands");

endmodule
